// ===== sv/srt_pkg.sv =====
// Shared types and codes for the sorted record table.
// Used by srt_cell and sorted_record_table; no dependencies.
`default_nettype none

package srt_pkg;

  // One stored record: sort key, score and the 20 name characters.
  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] score;
    logic [63:0]        name_low;
    logic [63:0]        name_mid;
    logic [31:0]        name_high;
  } rec_t;

  // Per-cycle action of every cell in the chain
  typedef logic [1:0] cell_mode_t;
  localparam cell_mode_t CELL_HOLD = 2'd0;
  localparam cell_mode_t CELL_INS  = 2'd1;  // open a gap and drop the new record in
  localparam cell_mode_t CELL_DEL  = 2'd2;  // close up over the first match
  localparam cell_mode_t CELL_ROT  = 2'd3;  // rotate toward cell 0

  typedef struct packed {
    cell_mode_t mode;
    rec_t       op_rec;   // record of the word in progress; key is the search key
  } cell_ctl_t;

  typedef struct packed {
    logic ge_free;  // free, or holding a key >= search key
    logic ge;       // holding a key >= search key
    logic match;    // holding a key equal to search key
  } cell_stat_t;

  // Command codes
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_DELETE = 2'd1;
  localparam cmd_t CMD_LIST   = 2'd2;

  // Result status codes
  typedef logic [2:0] status_t;
  localparam status_t STAT_DONE     = 3'd0;
  localparam status_t STAT_FULL     = 3'd1;
  localparam status_t STAT_NOTFOUND = 3'd2;
  localparam status_t STAT_LISTED   = 3'd3;
  localparam status_t STAT_EMPTY    = 3'd4;

endpackage

`default_nettype wire

// ===== sv/srt_cell.sv =====
// One slot of the sorted record chain: holds a record, compares it to the
// search key and takes a neighbor's record on shift. Depends on srt_pkg.
`default_nettype none

module srt_cell
  import srt_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctl_t  ctl,
  input  wire logic       occ,        // slot lies below the fill count
  input  wire logic       g_left,     // ge_free of the left neighbor
  input  wire rec_t       left_rec,
  input  wire rec_t       right_rec,
  output cell_stat_t      stat,
  output rec_t            rec
);

  rec_t rec_r;
  rec_t rec_nxt;
  logic ge;

  assign ge = occ && (rec_r.key >= ctl.op_rec.key);

  assign stat.ge      = ge;
  assign stat.ge_free = ge || !occ;
  assign stat.match   = occ && (rec_r.key == ctl.op_rec.key);
  assign rec          = rec_r;

  always_comb begin
    rec_nxt = rec_r;
    unique case (ctl.mode)
      CELL_HOLD: rec_nxt = rec_r;
      CELL_INS: begin
        if (g_left) begin
          rec_nxt = left_rec;
        end else if (stat.ge_free) begin
          rec_nxt = ctl.op_rec;
        end
      end
      CELL_DEL: begin
        if (ge) begin
          rec_nxt = right_rec;
        end
      end
      CELL_ROT: rec_nxt = right_rec;
      default: rec_nxt = rec_r;
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/sorted_record_table.sv =====
// Top level of the sorted record table: control sequencer, fill count,
// output register and the chain of srt_cell slots. Depends on srt_pkg.
`default_nettype none

// Holds up to TABLE_DEPTH records sorted by ascending signed number in a row
// of cells that shift as a whole. One word is worked on at a time; in_stall is
// high while a word is in progress. An insert works in the chain in S_INS and
// then posts its result from S_RESP; a delete closes up once per matching
// record in S_DEL, then posts its result; a list rotates the whole chain once
// through cell 0 and holds while a listed record waits in the output
// register. An empty list posts STAT_EMPTY. Posting a status result also
// waits while the output register is stalled. The output register lets a new
// word be taken while the last result is still waiting. No clearing pass is
// needed after reset.
module sorted_record_table
  import srt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_cmd,
  input  wire logic signed [31:0] in_student_number,
  input  wire logic signed [31:0] in_score,
  input  wire logic [63:0]        in_name_bytes_low,
  input  wire logic [63:0]        in_name_bytes_mid,
  input  wire logic [31:0]        in_name_bytes_high,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_status,
  output logic signed [31:0]      out_number,
  output logic signed [31:0]      out_score,
  output logic [63:0]             out_name_low,
  output logic [63:0]             out_name_mid,
  output logic [31:0]             out_name_high,
  output logic                    out_last
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = $clog2(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_DEL  = 3'd2;
  localparam logic [2:0] S_LIST = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             found_r, found_nxt;
  status_t          resp_r, resp_nxt;
  rec_t             op_rec_r, op_rec_nxt;

  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  rec_t             out_rec_r, out_rec_nxt;
  logic             out_last_r, out_last_nxt;

  cell_ctl_t        ctl;
  cell_stat_t       stat [TABLE_DEPTH];
  rec_t             recs [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] occ;
  logic [TABLE_DEPTH-1:0] match_vec;
  logic             any_match;
  logic             full;
  logic             out_free;
  logic             accept;
  logic             k_in_list;
  logic             rot;

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      logic g_left;
      if (gi == 0) begin : g_first
        assign g_left = 1'b0;
      end else begin : g_rest
        assign g_left = stat[gi-1].ge_free;
      end
      assign occ[gi]       = CNT_W'(gi) < count_r;
      assign match_vec[gi] = stat[gi].match;

      srt_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .occ      (occ[gi]),
        .g_left   (g_left),
        .left_rec (recs[(gi + TABLE_DEPTH - 1) % TABLE_DEPTH]),
        .right_rec(recs[(gi + 1) % TABLE_DEPTH]),
        .stat     (stat[gi]),
        .rec      (recs[gi])
      );
    end
  endgenerate

  assign any_match = |match_vec;
  assign full      = count_r == CNT_W'(TABLE_DEPTH);
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = state_r != S_IDLE;
  assign accept    = in_valid && !in_stall;
  assign k_in_list = CNT_W'(k_r) < count_r;
  // rotation only waits on the output when cell 0 holds a record to list
  assign rot       = (state_r == S_LIST) && (count_r != '0) && (!k_in_list || out_free);

  always_comb begin
    ctl.op_rec = op_rec_r;
    unique case (state_r)
      S_INS:   ctl.mode = full ? CELL_HOLD : CELL_INS;
      S_DEL:   ctl.mode = any_match ? CELL_DEL : CELL_HOLD;
      S_LIST:  ctl.mode = rot ? CELL_ROT : CELL_HOLD;
      default: ctl.mode = CELL_HOLD;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    k_nxt          = k_r;
    found_nxt      = found_r;
    resp_nxt       = resp_r;
    op_rec_nxt     = op_rec_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_rec_nxt    = out_rec_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_rec_nxt.key       = in_student_number;
          op_rec_nxt.score     = in_score;
          op_rec_nxt.name_low  = in_name_bytes_low;
          op_rec_nxt.name_mid  = in_name_bytes_mid;
          op_rec_nxt.name_high = in_name_bytes_high;
          found_nxt            = 1'b0;
          k_nxt                = '0;
          priority if (in_cmd == CMD_INSERT) begin
            state_nxt = S_INS;
          end else if (in_cmd == CMD_DELETE) begin
            state_nxt = S_DEL;
          end else if (in_cmd == CMD_LIST) begin
            state_nxt = S_LIST;
          end else begin
            // unused code: dropped without a result
            state_nxt = S_IDLE;
          end
        end
      end
      S_INS: begin
        if (full) begin
          resp_nxt = STAT_FULL;
        end else begin
          resp_nxt  = STAT_DONE;
          count_nxt = count_r + 1'b1;
        end
        state_nxt = S_RESP;
      end
      S_DEL: begin
        // equal keys sit side by side, so one close-up per cycle clears them
        if (any_match) begin
          found_nxt = 1'b1;
          count_nxt = count_r - 1'b1;
        end else begin
          resp_nxt  = found_r ? STAT_DONE : STAT_NOTFOUND;
          state_nxt = S_RESP;
        end
      end
      S_LIST: begin
        if (count_r == '0) begin
          resp_nxt  = STAT_EMPTY;
          state_nxt = S_RESP;
        end else if (rot) begin
          if (k_in_list) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_LISTED;
            out_rec_nxt    = recs[0];
            out_last_nxt   = (CNT_W'(k_r) + 1'b1) == count_r;
          end
          if (k_r == IDX_W'(TABLE_DEPTH - 1)) begin
            k_nxt     = '0;
            state_nxt = S_IDLE;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = resp_r;
          out_rec_nxt    = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    resp_r       <= resp_nxt;
    op_rec_r     <= op_rec_nxt;
    out_status_r <= out_status_nxt;
    out_rec_r    <= out_rec_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_number    = out_rec_r.key;
  assign out_score     = out_rec_r.score;
  assign out_name_low  = out_rec_r.name_low;
  assign out_name_mid  = out_rec_r.name_mid;
  assign out_name_high = out_rec_r.name_high;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire
